// ----- rtl/swd_pkg.sv -----
package swd_pkg;

  localparam int KIND_W      = 3;
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 6;
  localparam int HALF_W      = 16;
  localparam int S_TDATA_W   = 40;
  localparam int M_TDATA_W   = 40;

  localparam int MAX_BITS_DEF      = 32;
  localparam int DIVIDER_WIDTH_DEF = 16;

  localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd50;

  localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE_PAR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE_RAW = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ_PAR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_RAW  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RELEASE   = 3'd5;

  function automatic logic is_write(input logic [KIND_W-1:0] k);
    return (k == KIND_WRITE_PAR) || (k == KIND_WRITE_RAW);
  endfunction

  function automatic logic is_read(input logic [KIND_W-1:0] k);
    return (k == KIND_READ_PAR) || (k == KIND_READ_RAW);
  endfunction

  function automatic logic has_parity(input logic [KIND_W-1:0] k);
    return (k == KIND_WRITE_PAR) || (k == KIND_READ_PAR);
  endfunction

endpackage

// ----- rtl/swd_line_engine.sv -----
// Each result is registered in a two-entry output stage (output, then skid entry), which
// keeps s_axis_tready high while one result waits. Throughput: one request per cycle while
// the skid entry is empty; the divider steps per tick request, the bit sequencer per wrap.
// Reset: synchronous rst clears the sequencer to idle with the line floating, clock and data
// low, read data zero, parity status one, and loads half_period with 50.
module swd_line_engine #(
  parameter int MAX_BITS      = swd_pkg::MAX_BITS_DEF,
  parameter int DIVIDER_WIDTH = swd_pkg::DIVIDER_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [swd_pkg::HALF_W-1:0]     cfg_wr_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // data[31:0], bit_count[37:32], line_in[38], zero[39]
  input  logic [swd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // kind[2:0]
  input  logic [swd_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // clock_out[0], data_out[1], drive_enable[2], busy_res[3], done_res[4],
  // read_data[36:5], parity_ok[37], rejected[38], zero[39]
  output logic [swd_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
  import swd_pkg::*;

  localparam int BIT_W = $clog2(MAX_BITS + 1);
  localparam int IDX_W = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int DW    = DIVIDER_WIDTH;

  typedef enum logic [2:0] {
    PH_IDLE, PH_TURN_LO, PH_TURN_HI, PH_BIT_LO, PH_BIT_HI, PH_PAR_LO, PH_PAR_HI
  } phase_t;

  logic [HALF_W-1:0]   half_period;
  logic                drive_state,        drive_state_next;
  phase_t              phase,              phase_next;
  logic [KIND_W-1:0]   command_kind,       command_kind_next;
  logic [MAX_BITS-1:0] shift_word,         shift_word_next;
  logic [BIT_W-1:0]    bit_index,          bit_index_next;
  logic [BIT_W-1:0]    bits_wanted,        bits_wanted_next;
  logic [DW-1:0]       divider_count,      divider_count_next;
  logic                parity_acc,         parity_acc_next;
  logic                clock_level,        clock_level_next;
  logic                data_level,         data_level_next;
  logic [MAX_BITS-1:0] last_read,          last_read_next;
  logic                last_parity_ok,     last_parity_ok_next;

  logic                out_valid;
  logic [M_TDATA_W-1:0] out_data;
  logic                skid_valid;
  logic [M_TDATA_W-1:0] skid_data;

  logic [DATA_W-1:0]   in_data;
  logic [COUNT_W-1:0]  in_count;
  logic                in_line;
  logic [DW-1:0]       hp_eff;
  logic                s_fire, m_fire;
  logic                step, fin, res_done, res_rej, res_busy, res_drive;
  logic [M_TDATA_W-1:0] res_data;

  assign in_data  = s_axis_tdata[DATA_W-1:0];
  assign in_count = s_axis_tdata[DATA_W+COUNT_W-1:DATA_W];
  assign in_line  = s_axis_tdata[DATA_W+COUNT_W];

  assign hp_eff = (DW'(half_period) == '0) ? DW'(1) : DW'(half_period);

  assign s_axis_tready = !skid_valid;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_fire        = out_valid && m_axis_tready;

  always_comb begin
    drive_state_next    = drive_state;
    phase_next          = phase;
    command_kind_next   = command_kind;
    shift_word_next     = shift_word;
    bit_index_next      = bit_index;
    bits_wanted_next    = bits_wanted;
    divider_count_next  = divider_count;
    parity_acc_next     = parity_acc;
    clock_level_next    = clock_level;
    data_level_next     = data_level;
    last_read_next      = last_read;
    last_parity_ok_next = last_parity_ok;
    step    = 1'b0;
    fin     = 1'b0;
    res_rej = 1'b0;

    case (s_axis_tuser)
      KIND_TICK: begin
        if (phase != PH_IDLE) begin
          if (({1'b0, divider_count} + (DW + 1)'(1)) >= {1'b0, hp_eff}) begin
            divider_count_next = '0;
            case (phase)
              PH_TURN_LO: begin
                clock_level_next = 1'b1;
                phase_next       = PH_TURN_HI;
              end
              PH_TURN_HI: begin
                clock_level_next = 1'b0;
                step             = 1'b1;
              end
              PH_BIT_LO: begin
                if (is_read(command_kind)) begin
                  shift_word_next[bit_index[IDX_W-1:0]] =
                    shift_word[bit_index[IDX_W-1:0]] | in_line;
                  parity_acc_next = parity_acc ^ in_line;
                end
                clock_level_next = 1'b1;
                phase_next       = PH_BIT_HI;
              end
              PH_BIT_HI: begin
                clock_level_next = 1'b0;
                bit_index_next   = bit_index + BIT_W'(1);
                step             = 1'b1;
              end
              PH_PAR_LO: begin
                if (is_read(command_kind)) begin
                  parity_acc_next = parity_acc ^ in_line;
                end
                clock_level_next = 1'b1;
                phase_next       = PH_PAR_HI;
              end
              PH_PAR_HI: begin
                clock_level_next = 1'b0;
                fin              = 1'b1;
              end
              default: begin
                phase_next = PH_IDLE;
              end
            endcase
          end else begin
            divider_count_next = divider_count + DW'(1);
          end
        end
      end
      KIND_WRITE_PAR, KIND_WRITE_RAW, KIND_READ_PAR, KIND_READ_RAW, KIND_RELEASE: begin
        if (phase != PH_IDLE) begin
          res_rej = 1'b1;
        end else begin
          command_kind_next = s_axis_tuser;
          if (s_axis_tuser == KIND_RELEASE) begin
            bits_wanted_next = '0;
          end else if (32'(in_count) > 32'(MAX_BITS)) begin
            bits_wanted_next = BIT_W'(MAX_BITS);
          end else begin
            bits_wanted_next = BIT_W'(in_count);
          end
          shift_word_next    = is_write(s_axis_tuser) ? MAX_BITS'(in_data) : '0;
          bit_index_next     = '0;
          parity_acc_next    = 1'b0;
          divider_count_next = '0;
          if (drive_state != is_write(s_axis_tuser)) begin
            drive_state_next = is_write(s_axis_tuser);
            phase_next       = PH_TURN_LO;
          end else begin
            step = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (step) begin
      if (bit_index_next < bits_wanted_next) begin
        phase_next = PH_BIT_LO;
        if (is_write(command_kind_next)) begin
          data_level_next = shift_word_next[bit_index_next[IDX_W-1:0]];
          parity_acc_next = parity_acc_next ^ shift_word_next[bit_index_next[IDX_W-1:0]];
        end
      end else if (has_parity(command_kind_next)) begin
        phase_next = PH_PAR_LO;
        if (is_write(command_kind_next)) begin
          data_level_next = parity_acc_next;
        end
      end else begin
        fin = 1'b1;
      end
    end

    if (fin) begin
      if (is_read(command_kind_next)) begin
        last_read_next      = shift_word_next;
        last_parity_ok_next = has_parity(command_kind_next) ? !parity_acc_next : 1'b1;
      end
      phase_next = PH_IDLE;
    end
  end

  assign res_done  = fin;
  assign res_busy  = (phase_next != PH_IDLE);
  assign res_drive = drive_state_next && (phase_next != PH_TURN_LO)
                     && (phase_next != PH_TURN_HI);
  assign res_data  = {1'b0, res_rej, last_parity_ok_next, 32'(last_read_next),
                      res_done, res_busy, res_drive, data_level_next, clock_level_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period    <= HALF_PERIOD_RESET;
      drive_state    <= 1'b0;
      phase          <= PH_IDLE;
      command_kind   <= KIND_TICK;
      shift_word     <= '0;
      bit_index      <= '0;
      bits_wanted    <= '0;
      divider_count  <= '0;
      parity_acc     <= 1'b0;
      clock_level    <= 1'b0;
      data_level     <= 1'b0;
      last_read      <= '0;
      last_parity_ok <= 1'b1;
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        half_period <= cfg_wr_data;
      end
      if (s_fire) begin
        drive_state    <= drive_state_next;
        phase          <= phase_next;
        command_kind   <= command_kind_next;
        shift_word     <= shift_word_next;
        bit_index      <= bit_index_next;
        bits_wanted    <= bits_wanted_next;
        divider_count  <= divider_count_next;
        parity_acc     <= parity_acc_next;
        clock_level    <= clock_level_next;
        data_level     <= data_level_next;
        last_read      <= last_read_next;
        last_parity_ok <= last_parity_ok_next;
      end
      if (skid_valid) begin
        if (m_fire) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end
      end else if (s_fire) begin
        if (!out_valid || m_fire) begin
          out_data  <= res_data;
          out_valid <= 1'b1;
        end else begin
          skid_data  <= res_data;
          skid_valid <= 1'b1;
        end
      end else if (m_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output entry");

  a_reject_only_busy: assert property (@(posedge clk) disable iff (rst)
    (s_fire && res_rej) |-> (phase != PH_IDLE) && res_busy)
    else $error("request rejected while idle");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    (s_fire && res_done) |=> (phase == PH_IDLE))
    else $error("sequencer still running after done");

  a_turn_floats: assert property (@(posedge clk) disable iff (rst)
    (s_fire && ((phase_next == PH_TURN_LO) || (phase_next == PH_TURN_HI))) |-> !res_drive)
    else $error("line driven during turnaround");
`endif

endmodule
